/* src/kot_pkg.sv */
// Package for the keyed ordered table: command and status codes and the
// control group broadcast to every cell. No dependencies.
`default_nettype none

package kot_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } kot_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } kot_status_e;

  // Shift controls for the row of cells.
  typedef struct packed {
    logic ins;  // every cell takes its left neighbor
    logic del;  // cells at or after the first match take their right neighbor
  } kot_ctrl_t;

endpackage

`default_nettype wire

/* src/kot_cell.sv */
// One cell of the keyed ordered table: holds one entry and its valid bit,
// compares it with the broadcast key and shifts toward either neighbor.
// Depends on kot_pkg.
`default_nettype none

module kot_cell import kot_pkg::*; #(
  parameter int KEY_BITS      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire kot_ctrl_t                ctrl_i,
  input  wire logic [KEY_BITS-1:0]      key_i,
  input  wire logic [KEY_BITS-1:0]      left_key_i,
  input  wire logic [PRIORITY_BITS-1:0] left_prio_i,
  input  wire logic                     left_valid_i,
  input  wire logic [KEY_BITS-1:0]      right_key_i,
  input  wire logic [PRIORITY_BITS-1:0] right_prio_i,
  input  wire logic                     right_valid_i,
  input  wire logic                     claim_i,
  input  wire logic [PRIORITY_BITS-1:0] found_i,
  output logic                          claim_o,
  output logic [PRIORITY_BITS-1:0]      found_o,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [PRIORITY_BITS-1:0]      prio_o,
  output logic                          valid_o
);

  logic [KEY_BITS-1:0]      key_q, key_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                     valid_q, valid_d;
  logic                     hit;

  assign hit = valid_q && (key_q == key_i);

  // A newer cell that already matched claims the item; older cells pass it on.
  assign claim_o = claim_i | hit;
  assign found_o = claim_i ? found_i : (hit ? prio_q : '0);

  always_comb begin
    key_d   = key_q;
    prio_d  = prio_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      key_d   = left_key_i;
      prio_d  = left_prio_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.del && claim_o) begin
      key_d   = right_key_i;
      prio_d  = right_prio_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prio_q <= prio_d;
  end

  assign key_o   = key_q;
  assign prio_o  = prio_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* src/keyed_ordered_table.sv */
// Top level of the keyed ordered table: a row of kot_cell instances and the
// output register. Depends on kot_pkg and kot_cell.
`default_nettype none

// The table keeps up to ENTRIES (key, priority) entries newest first in a row
// of cells, one entry per cell. Every item is executed in the cycle it is
// accepted: all cells compare the key at once, the first match is found by a
// claim signal that ripples from the newest cell to the oldest, and the row
// shifts by one place for an insert or a delete. One item is taken per cycle
// while the output is not stalled, and its result appears on the output in
// the next cycle. Claim and found-priority ripple along the row sets the
// cycle time. Reset empties the table at once; no clearing pass is needed.
module keyed_ordered_table import kot_pkg::*; #(
  parameter int ENTRIES       = 16,
  parameter int KEY_BITS      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               command_i,
  input  wire logic [KEY_BITS-1:0]      key_i,
  input  wire logic [PRIORITY_BITS-1:0] priority_req_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic [PRIORITY_BITS-1:0]      found_priority_o
);

  logic [KEY_BITS-1:0]      cell_key   [ENTRIES];
  logic [PRIORITY_BITS-1:0] cell_prio  [ENTRIES];
  logic [ENTRIES-1:0]       cell_valid;
  logic [ENTRIES:0]         claim;
  logic [PRIORITY_BITS-1:0] found      [ENTRIES+1];

  kot_cmd_e    cmd;
  kot_ctrl_t   ctrl;
  kot_status_e status_d;
  logic        in_accept, full, empty, any_hit;

  logic                     out_valid_q;
  logic [1:0]               status_q;
  logic [PRIORITY_BITS-1:0] found_q, found_d;

  assign cmd        = kot_cmd_e'(command_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = cell_valid[ENTRIES-1];
  assign empty      = !cell_valid[0];
  assign any_hit    = claim[ENTRIES];

  assign ctrl.ins = in_accept && (cmd == CMD_INSERT) && !full;
  assign ctrl.del = in_accept && (cmd == CMD_DELETE);

  assign claim[0] = 1'b0;
  assign found[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]      lk, rk;
    logic [PRIORITY_BITS-1:0] lp, rp;
    logic                     lv, rv;

    if (i == 0) begin : g_head
      assign lk = key_i;
      assign lp = priority_req_i;
      assign lv = 1'b1;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign lp = cell_prio[i-1];
      assign lv = cell_valid[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign rk = '0;
      assign rp = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rp = cell_prio[i+1];
      assign rv = cell_valid[i+1];
    end

    kot_cell #(
      .KEY_BITS      (KEY_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key_i),
      .left_key_i    (lk),
      .left_prio_i   (lp),
      .left_valid_i  (lv),
      .right_key_i   (rk),
      .right_prio_i  (rp),
      .right_valid_i (rv),
      .claim_i       (claim[i]),
      .found_i       (found[i]),
      .claim_o       (claim[i+1]),
      .found_o       (found[i+1]),
      .key_o         (cell_key[i]),
      .prio_o        (cell_prio[i]),
      .valid_o       (cell_valid[i])
    );
  end

  always_comb begin
    status_d = ST_DONE;
    found_d  = '0;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!any_hit) begin
          status_d = ST_NOT_FOUND;
        end else if (cmd == CMD_SEARCH) begin
          found_d = found[ENTRIES];
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_priority_o = found_q;

  // The occupied cells always form an unbroken run from the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + ENTRIES'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  // An accepted insert into a table with room fills the head cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> cell_valid[0])
    else $error("insert did not fill the head cell");

  // A delete with a match removes exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.del && any_hit) |=>
      ($countones(cell_valid) + 1 == $countones($past(cell_valid))))
    else $error("delete did not remove exactly one entry");

  // A full status is only reported while the table is still full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_FULL)) |-> full)
    else $error("full status reported with room in the table");

  // Every accepted item leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire
